// ===== rtl/vhfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vhfc_pkg: shared definitions for the voxel heightmap face culler
// Field widths, register and action codes, face codes, the job record passed
// from the fetch sequencer to the face emitter, and the color band function.
// ----------------------------------------------------------------------------
package vhfc_pkg;

  localparam int COL_W    = 6;
  localparam int LEVEL_W  = 6;
  localparam int HEIGHT_W = 7;
  localparam int ORIGIN_W = 21;
  localparam int WORLD_W  = 22;
  localparam int SIZE_W   = 7;
  localparam int SIDE_W   = 3;
  localparam int BAND_W   = 3;
  localparam int NUM_FACES = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ORIGIN_W;

  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 7'd1;
  localparam logic [SIZE_W-1:0]   RESET_SIZE   = 7'd16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd3;

  // Action codes of an input word.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CULL = 1'b1;

  // Face codes, also the bit positions in a visibility mask.
  localparam logic [SIDE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [SIDE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [SIDE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [SIDE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [SIDE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [SIDE_W-1:0] FACE_NEG_Z = 3'd5;

  localparam logic [BAND_W-1:0] TOP_BAND = 3'd6;
  // y/3 for y below 128 equals (y*43)>>7.
  localparam int BandRecip = 43;
  localparam int BandShift = 7;

  typedef struct packed {
    logic [NUM_FACES-1:0] mask;
    logic [BAND_W-1:0]    band;
    logic [WORLD_W-1:0]   world_x;
    logic [LEVEL_W-1:0]   world_y;
    logic [WORLD_W-1:0]   world_z;
  } face_job_t;

  function automatic logic [BAND_W-1:0] band_of(input logic [LEVEL_W-1:0] y);
    logic [LEVEL_W+BandShift-1:0] prod;
    logic [LEVEL_W-1:0]           third;
    prod  = {7'b0, y} * 13'(BandRecip);
    third = prod[BandShift +: LEVEL_W];
    if (third > {3'b0, TOP_BAND}) begin
      return TOP_BAND;
    end
    return third[BAND_W-1:0];
  endfunction

endpackage

// ===== rtl/vhfc_ram.sv =====
// ----------------------------------------------------------------------------
// vhfc_ram: generic synchronous RAM
// One write port and one read port, read data registered and held between
// reads.
// ----------------------------------------------------------------------------
module vhfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/vhfc_fetch.sv =====
// ----------------------------------------------------------------------------
// vhfc_fetch: heightmap store and neighbor read sequencer
// Owns the column height RAM, runs the clearing pass after reset, writes
// load words and reads the five columns a cull needs, then builds the face job.
// ----------------------------------------------------------------------------
module vhfc_fetch #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [vhfc_pkg::COL_W-1:0]       in_col_x,
  input  logic [vhfc_pkg::COL_W-1:0]       in_col_z,
  input  logic [vhfc_pkg::LEVEL_W-1:0]     in_level_y,
  input  logic [vhfc_pkg::HEIGHT_W-1:0]    in_height,
  input  logic [vhfc_pkg::ORIGIN_W-1:0]    origin_x,
  input  logic [vhfc_pkg::ORIGIN_W-1:0]    origin_z,
  input  logic [vhfc_pkg::SIZE_W-1:0]      size_x,
  input  logic [vhfc_pkg::SIZE_W-1:0]      size_z,
  output logic                             job_valid,
  input  logic                             job_ready,
  output vhfc_pkg::face_job_t              job
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [8:0] SIDE9 = 9'(MAX_SIDE);
  localparam logic [vhfc_pkg::HEIGHT_W-1:0] HMAX = vhfc_pkg::HEIGHT_W'(MAX_HEIGHT);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } fetch_state_t;

  fetch_state_t state_r, state_nxt;
  logic [2:0]                          cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]                   clr_addr_r, clr_addr_nxt;
  logic [vhfc_pkg::COL_W-1:0]          x_r, z_r;
  logic [vhfc_pkg::LEVEL_W-1:0]        y_r;
  logic [vhfc_pkg::HEIGHT_W-1:0]       h_ctr_r, h_px_r, h_nx_r, h_pz_r;

  logic                                wr_en, rd_en;
  logic [ADDR_W-1:0]                   wr_addr, rd_addr;
  logic [vhfc_pkg::HEIGHT_W-1:0]       wr_data, rd_data, sat_height;
  logic                                accept, load_ok, eval_go;
  logic [8:0]                          x9, z9, in_x9, in_z9, sx, sz;
  logic [vhfc_pkg::HEIGHT_W-1:0]       y7;
  logic                                in_chunk, solid;
  logic [vhfc_pkg::NUM_FACES-1:0]      vis, mask;

  function automatic logic [ADDR_W-1:0] col_addr(input logic [8:0] cx,
                                                 input logic [8:0] cz);
    logic [31:0] full;
    full = 32'(cz) * 32'(MAX_SIDE) + 32'(cx);
    return full[ADDR_W-1:0];
  endfunction

  vhfc_ram #(
    .WIDTH (vhfc_pkg::HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign x9    = {3'b0, x_r};
  assign z9    = {3'b0, z_r};
  assign in_x9 = {3'b0, in_col_x};
  assign in_z9 = {3'b0, in_col_z};
  assign y7    = {1'b0, y_r};

  // Effective sizes saturate at the chunk side.
  assign sx = ({2'b0, size_x} > SIDE9) ? SIDE9 : {2'b0, size_x};
  assign sz = ({2'b0, size_z} > SIDE9) ? SIDE9 : {2'b0, size_z};

  // Visibility; the last neighbor (-Z) is still on the RAM output here.
  always_comb begin
    in_chunk = (x9 < sx) && (z9 < sz);
    solid    = y7 < h_ctr_r;
    vis = '0;
    vis[vhfc_pkg::FACE_POS_X] = !(((x9 + 9'd1) < sx) && (y7 < h_px_r));
    vis[vhfc_pkg::FACE_NEG_X] = !((x9 != 9'd0) && (y7 < h_nx_r));
    vis[vhfc_pkg::FACE_POS_Y] = !((y7 + 7'd1) < h_ctr_r);
    vis[vhfc_pkg::FACE_NEG_Y] = (y_r == '0);
    vis[vhfc_pkg::FACE_POS_Z] = !(((z9 + 9'd1) < sz) && (y7 < h_pz_r));
    vis[vhfc_pkg::FACE_NEG_Z] = !((z9 != 9'd0) && (y7 < rd_data));
    mask = (in_chunk && solid) ? vis : '0;
  end

  assign job.mask    = mask;
  assign job.band    = vhfc_pkg::band_of(y_r);
  assign job.world_x = {origin_x[vhfc_pkg::ORIGIN_W-1], origin_x} + {16'b0, x_r};
  assign job.world_y = y_r;
  assign job.world_z = {origin_z[vhfc_pkg::ORIGIN_W-1], origin_z} + {16'b0, z_r};

  assign job_valid = (state_r == ST_EVAL) && (mask != '0);
  assign eval_go   = (mask == '0) || job_ready;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_EVAL) && eval_go);
  assign accept    = in_valid && in_ready;

  assign load_ok    = accept && (in_action == vhfc_pkg::ACT_LOAD) &&
                      (in_x9 < SIDE9) && (in_z9 < SIDE9);
  assign sat_height = (in_height > HMAX) ? HMAX : in_height;

  // The port is never wanted by a read and a write in the same cycle:
  // loads are only taken while no read is issued.
  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || load_ok;
    wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : col_addr(in_x9, in_z9);
    wr_data = (state_r == ST_CLEAR) ? vhfc_pkg::RESET_HEIGHT : sat_height;
    rd_en   = (state_r == ST_READ);
    case (cnt_r)
      3'd0:    rd_addr = col_addr(x9, z9);
      3'd1:    rd_addr = col_addr(x9 + 9'd1, z9);
      3'd2:    rd_addr = col_addr(x9 - 9'd1, z9);
      3'd3:    rd_addr = col_addr(x9, z9 + 9'd1);
      3'd4:    rd_addr = col_addr(x9, z9 - 9'd1);
      default: rd_addr = col_addr(x9, z9);
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_IDLE, ST_EVAL: begin
        if (in_ready) begin
          state_nxt = ST_IDLE;
          if (accept && (in_action == vhfc_pkg::ACT_CULL)) begin
            state_nxt = ST_READ;
            cnt_nxt   = 3'd0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_col_x;
      z_r <= in_col_z;
      y_r <= in_level_y;
    end
    if (state_r == ST_READ) begin
      case (cnt_r)
        3'd1:    h_ctr_r <= rd_data;
        3'd2:    h_px_r  <= rd_data;
        3'd3:    h_nx_r  <= rd_data;
        3'd4:    h_pz_r  <= rd_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/vhfc_emit.sv =====
// ----------------------------------------------------------------------------
// vhfc_emit: face emitter
// Holds one face job and sends one result word per set mask bit, lowest face
// code first, marking the last one.
// ----------------------------------------------------------------------------
module vhfc_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  vhfc_pkg::face_job_t           job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vhfc_pkg::SIDE_W-1:0]   out_side,
  output logic [vhfc_pkg::BAND_W-1:0]   out_band,
  output logic [vhfc_pkg::WORLD_W-1:0]  out_world_x,
  output logic [vhfc_pkg::LEVEL_W-1:0]  out_world_y,
  output logic [vhfc_pkg::WORLD_W-1:0]  out_world_z,
  output logic                          out_last
);

  logic                           busy_r, busy_nxt;
  logic [vhfc_pkg::NUM_FACES-1:0] mask_r, mask_nxt, lowest;
  vhfc_pkg::face_job_t            job_r;
  logic                           out_fire;

  assign lowest = mask_r & (~mask_r + 6'd1);

  always_comb begin
    out_side = '0;
    for (int i = vhfc_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        out_side = vhfc_pkg::SIDE_W'(i);
      end
    end
  end

  assign out_valid   = busy_r;
  assign out_last    = (mask_r & (mask_r - 6'd1)) == '0;
  assign out_band    = job_r.band;
  assign out_world_x = job_r.world_x;
  assign out_world_y = job_r.world_y;
  assign out_world_z = job_r.world_z;

  assign out_fire  = busy_r && out_ready;
  assign job_ready = !busy_r || (out_fire && out_last);

  always_comb begin
    busy_nxt = busy_r;
    mask_nxt = mask_r;
    if (job_valid && job_ready) begin
      busy_nxt = 1'b1;
      mask_nxt = job.mask;
    end else if (out_fire) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        mask_nxt = mask_r & ~lowest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (job_valid && job_ready) begin
      job_r <= job;
    end
  end

endmodule

// ===== rtl/voxel_heightmap_face_culler.sv =====
// ----------------------------------------------------------------------------
// voxel_heightmap_face_culler: heightmap store and visible face culler
// Top level with the configuration registers, the fetch sequencer and the
// face emitter.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  words carry either a column height load (in_tuser low) or a cull
//         request for one block (in_tuser high).
//   out_* words carry one visible face each; out_tlast marks the last face
//         of a block. A culled block that shows no face sends nothing.
//   cfg_* writes the origin and size registers; cfg_ready is always high.
// Flow: loads are taken back to back. A cull holds the single heightmap
//   read port for five reads plus an evaluate step, and the next word is
//   taken in that evaluate step at the earliest; the face emitter drains
//   up to six faces of the previous block meanwhile. The first face of a
//   cull is offered once the emitter has taken and registered its job.
// Reset: after rst_n is released a clearing pass writes height one into all
//   MAX_SIDE*MAX_SIDE columns (4096 at the default), with in_tready
//   low; configuration writes are taken during the pass.
// Stall: a face held by out_tready low stays stable; the next cull's reads
//   continue, and in_tready drops once its job cannot be handed over.
// ----------------------------------------------------------------------------
module voxel_heightmap_face_culler #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // col_x[5:0], col_z[11:6], level_y[17:12], height_value[24:18]
  input  logic [31:0] in_tdata,
  // action[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // color_band[2:0], world_x[24:3], world_y[30:25], world_z[52:31]
  output logic [55:0] out_tdata,
  // face_side[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [vhfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vhfc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [vhfc_pkg::ORIGIN_W-1:0] origin_x_r, origin_z_r;
  logic [vhfc_pkg::SIZE_W-1:0]   size_x_r, size_z_r;

  logic                          job_valid, job_ready;
  vhfc_pkg::face_job_t           job;
  logic [vhfc_pkg::BAND_W-1:0]   out_band;
  logic [vhfc_pkg::WORLD_W-1:0]  out_world_x, out_world_z;
  logic [vhfc_pkg::LEVEL_W-1:0]  out_world_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_z_r <= '0;
      size_x_r   <= vhfc_pkg::RESET_SIZE;
      size_z_r   <= vhfc_pkg::RESET_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vhfc_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        vhfc_pkg::CFG_ORIGIN_Z: origin_z_r <= cfg_data;
        vhfc_pkg::CFG_SIZE_X:   size_x_r   <= cfg_data[vhfc_pkg::SIZE_W-1:0];
        vhfc_pkg::CFG_SIZE_Z:   size_z_r   <= cfg_data[vhfc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  vhfc_fetch #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_fetch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser[0]),
    .in_col_x   (in_tdata[5:0]),
    .in_col_z   (in_tdata[11:6]),
    .in_level_y (in_tdata[17:12]),
    .in_height  (in_tdata[24:18]),
    .origin_x   (origin_x_r),
    .origin_z   (origin_z_r),
    .size_x     (size_x_r),
    .size_z     (size_z_r),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  vhfc_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_side    (out_tuser),
    .out_band    (out_band),
    .out_world_x (out_world_x),
    .out_world_y (out_world_y),
    .out_world_z (out_world_z),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b0, out_world_z, out_world_y, out_world_x, out_band};

endmodule

// ===== rtl/vhfc_checker.sv =====
// ----------------------------------------------------------------------------
// vhfc_checker: port-level checks for the face culler
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module vhfc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast
);

  logic [vhfc_pkg::BAND_W-1:0] band_exp;

  assign band_exp = vhfc_pkg::band_of(out_tdata[30:25]);

  // Reset empties the emitter and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("word offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

  // Faces of one block follow each other without gaps and in rising order.
  a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tuser > $past(out_tuser)))
    else $error("face sequence broken inside a block");

  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] == band_exp)
    else $error("color band does not match block level");

endmodule

bind voxel_heightmap_face_culler vhfc_checker u_vhfc_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for voxel_heightmap_face_culler
// Loads column heights, culls blocks against them and compares each visible
// face word with a behavioral predictor of the heightmap, under several chunk
// origins and sizes and with random gaps on the input and output streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 20;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int MAX_SIDE       = 64;
  localparam int MAX_HEIGHT     = 64;
  localparam int BAND_STEP      = 3;

  typedef struct {
    logic                          action;
    logic [vhfc_pkg::COL_W-1:0]    col_x;
    logic [vhfc_pkg::COL_W-1:0]    col_z;
    logic [vhfc_pkg::LEVEL_W-1:0]  level_y;
    logic [vhfc_pkg::HEIGHT_W-1:0] height_value;
  } block_word_t;

  typedef struct {
    logic [vhfc_pkg::SIDE_W-1:0]  side;
    logic [vhfc_pkg::BAND_W-1:0]  band;
    logic [vhfc_pkg::WORLD_W-1:0] world_x;
    logic [vhfc_pkg::LEVEL_W-1:0] world_y;
    logic [vhfc_pkg::WORLD_W-1:0] world_z;
    logic                         last;
  } face_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vhfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vhfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  voxel_heightmap_face_culler #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state, updated as words and register writes are accepted.
  logic [vhfc_pkg::HEIGHT_W-1:0] col_height [MAX_SIDE*MAX_SIDE];
  logic [vhfc_pkg::ORIGIN_W-1:0] reg_origin_x;
  logic [vhfc_pkg::ORIGIN_W-1:0] reg_origin_z;
  logic [vhfc_pkg::SIZE_W-1:0]   reg_size_x;
  logic [vhfc_pkg::SIZE_W-1:0]   reg_size_z;
  face_t                         faces_due[$];

  // Heights as the stimulus generator expects them once its words are taken.
  logic [vhfc_pkg::HEIGHT_W-1:0] plan_height [MAX_SIDE*MAX_SIDE];
  int                            plan_sx;
  int                            plan_sz;

  block_word_t word_q[$];
  block_word_t cur_word;
  bit          word_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fault_count = 0;

  function automatic logic [vhfc_pkg::HEIGHT_W-1:0] clip_height(
      input logic [vhfc_pkg::HEIGHT_W-1:0] h);
    return (h > MAX_HEIGHT) ? vhfc_pkg::HEIGHT_W'(MAX_HEIGHT) : h;
  endfunction

  function automatic int clip_size(input logic [vhfc_pkg::SIZE_W-1:0] s);
    return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
  endfunction

  // Columns beyond the store read as empty.
  function automatic int height_of(input int x, input int z);
    if (x >= MAX_SIDE || z >= MAX_SIDE) begin
      return 0;
    end
    return int'(col_height[x + z * MAX_SIDE]);
  endfunction

  task automatic predict_faces(input block_word_t w);
    int x, z, y, h, sx, sz, third;
    logic [vhfc_pkg::NUM_FACES-1:0] shown;
    face_t f;
    x = w.col_x;
    z = w.col_z;
    y = w.level_y;
    if (w.action == vhfc_pkg::ACT_LOAD) begin
      col_height[x + z * MAX_SIDE] = clip_height(w.height_value);
      return;
    end
    sx = clip_size(reg_size_x);
    sz = clip_size(reg_size_z);
    if (x >= sx || z >= sz) begin
      return;
    end
    h = height_of(x, z);
    if (y >= h) begin
      return;
    end
    shown[vhfc_pkg::FACE_POS_X] = !(x + 1 < sx && y < height_of(x + 1, z));
    shown[vhfc_pkg::FACE_NEG_X] = !(x >= 1 && y < height_of(x - 1, z));
    shown[vhfc_pkg::FACE_POS_Y] = !(y + 1 < h);
    shown[vhfc_pkg::FACE_NEG_Y] = (y == 0);
    shown[vhfc_pkg::FACE_POS_Z] = !(z + 1 < sz && y < height_of(x, z + 1));
    shown[vhfc_pkg::FACE_NEG_Z] = !(z >= 1 && y < height_of(x, z - 1));
    third = y / BAND_STEP;
    f.band = (third > vhfc_pkg::TOP_BAND) ? vhfc_pkg::TOP_BAND
                                          : vhfc_pkg::BAND_W'(third);
    f.world_x = {reg_origin_x[vhfc_pkg::ORIGIN_W-1], reg_origin_x} +
                vhfc_pkg::WORLD_W'(x);
    f.world_z = {reg_origin_z[vhfc_pkg::ORIGIN_W-1], reg_origin_z} +
                vhfc_pkg::WORLD_W'(z);
    f.world_y = w.level_y;
    f.last = 1'b0;
    for (int s = vhfc_pkg::FACE_POS_X; s <= vhfc_pkg::FACE_NEG_Z; s++) begin
      if (shown[s]) begin
        f.side = vhfc_pkg::SIDE_W'(s);
        faces_due = {faces_due, f};
      end
    end
    // A solid block buried on every side shows no face at all.
    if (shown != '0) begin
      faces_due[faces_due.size() - 1].last = 1'b1;
    end
  endtask

  // Input driver: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_faces(cur_word);
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || word_taken)) begin
      word_taken = 1'b0;
      if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word = word_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, cur_word.height_value, cur_word.level_y,
                      cur_word.col_z, cur_word.col_x};
        in_tuser  <= cur_word.action;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(input string field,
                             input logic [vhfc_pkg::WORLD_W-1:0] want,
                             input logic [vhfc_pkg::WORLD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fault_count++;
    end
  endtask

  // Face monitor.
  always @(posedge clk) begin : face_monitor
    face_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (faces_due.size() == 0) begin
        $error("face word with no face pending: side %0d at (0x%0h, %0d, 0x%0h)",
               out_tuser, out_tdata[24:3], out_tdata[30:25], out_tdata[52:31]);
        fault_count++;
      end else begin
        due = faces_due.pop_front();
        check_field("face_side", due.side, out_tuser);
        check_field("color_band", due.band, out_tdata[2:0]);
        check_field("world_x", due.world_x, out_tdata[24:3]);
        check_field("world_y", due.world_y, out_tdata[30:25]);
        check_field("world_z", due.world_z, out_tdata[52:31]);
        check_field("last_face", due.last, out_tlast);
      end
    end
  end

  task automatic queue_word(input logic action, input int x, input int z, input int y,
                            input int h);
    block_word_t w;
    w.action = action;
    w.col_x = vhfc_pkg::COL_W'(x);
    w.col_z = vhfc_pkg::COL_W'(z);
    w.level_y = vhfc_pkg::LEVEL_W'(y);
    w.height_value = vhfc_pkg::HEIGHT_W'(h);
    if (action == vhfc_pkg::ACT_LOAD) begin
      plan_height[x + z * MAX_SIDE] = clip_height(w.height_value);
    end
    word_q = {word_q, w};
  endtask

  // Mostly loads and culls inside the chunk, with culls aimed at solid blocks.
  task automatic queue_random(input int count);
    int x, z, y, h, lim_x, lim_z;
    for (int i = 0; i < count; i++) begin
      lim_x = (plan_sx == 0 || $urandom_range(9) == 0) ? MAX_SIDE : plan_sx;
      lim_z = (plan_sz == 0 || $urandom_range(9) == 0) ? MAX_SIDE : plan_sz;
      x = $urandom_range(lim_x - 1, 0);
      z = $urandom_range(lim_z - 1, 0);
      y = $urandom_range(2**vhfc_pkg::LEVEL_W - 1, 0);
      h = $urandom_range(2**vhfc_pkg::HEIGHT_W - 1, 0);
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(99) >= 15) begin
          h = $urandom_range(MAX_HEIGHT, 0);
        end
        queue_word(vhfc_pkg::ACT_LOAD, x, z, y, h);
      end else begin
        if (plan_height[x + z * MAX_SIDE] > 0 && $urandom_range(99) < 80) begin
          y = $urandom_range(plan_height[x + z * MAX_SIDE] - 1, 0);
        end
        queue_word(vhfc_pkg::ACT_CULL, x, z, y, h);
      end
    end
  endtask

  // Returns once every word is taken, every face has arrived and a cull that
  // shows nothing has had time to finish.
  task automatic wait_drained();
    @(posedge clk);
    while (word_q.size() > 0 || in_tvalid || faces_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vhfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vhfc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      vhfc_pkg::CFG_ORIGIN_X: reg_origin_x = value;
      vhfc_pkg::CFG_ORIGIN_Z: reg_origin_z = value;
      vhfc_pkg::CFG_SIZE_X:   reg_size_x = value[vhfc_pkg::SIZE_W-1:0];
      vhfc_pkg::CFG_SIZE_Z:   reg_size_z = value[vhfc_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // A write to an unused index goes first; it must leave every register alone.
  task automatic set_chunk(input logic [vhfc_pkg::ORIGIN_W-1:0] ox,
                           input logic [vhfc_pkg::ORIGIN_W-1:0] oz,
                           input logic [vhfc_pkg::SIZE_W-1:0] sx,
                           input logic [vhfc_pkg::SIZE_W-1:0] sz);
    write_reg(vhfc_pkg::CFG_IDX_W'($urandom_range(2**vhfc_pkg::CFG_IDX_W - 1,
                                                  vhfc_pkg::CFG_SIZE_Z + 1)),
              vhfc_pkg::CFG_DATA_W'($urandom));
    write_reg(vhfc_pkg::CFG_ORIGIN_X, ox);
    write_reg(vhfc_pkg::CFG_ORIGIN_Z, oz);
    write_reg(vhfc_pkg::CFG_SIZE_X, vhfc_pkg::CFG_DATA_W'(sx));
    write_reg(vhfc_pkg::CFG_SIZE_Z, vhfc_pkg::CFG_DATA_W'(sz));
    @(negedge clk);
    cfg_valid <= 1'b0;
    plan_sx = clip_size(sx);
    plan_sz = clip_size(sz);
  endtask

  initial begin
    for (int i = 0; i < MAX_SIDE * MAX_SIDE; i++) begin
      col_height[i] = vhfc_pkg::RESET_HEIGHT;
      plan_height[i] = vhfc_pkg::RESET_HEIGHT;
    end
    reg_origin_x = '0;
    reg_origin_z = '0;
    reg_size_x = vhfc_pkg::RESET_SIZE;
    reg_size_z = vhfc_pkg::RESET_SIZE;
    plan_sx = vhfc_pkg::RESET_SIZE;
    plan_sz = vhfc_pkg::RESET_SIZE;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 78;
    set_chunk(21'h100000, 21'h0FFFFF, 7'd16, 7'd16);
    // Saturated, empty and out-of-chunk columns, then culls around them.
    queue_word(vhfc_pkg::ACT_LOAD, 0, 0, 63, 127);
    queue_word(vhfc_pkg::ACT_LOAD, 1, 0, 0, 0);
    queue_word(vhfc_pkg::ACT_LOAD, 0, 1, 21, 63);
    queue_word(vhfc_pkg::ACT_LOAD, 63, 63, 0, 5);
    queue_word(vhfc_pkg::ACT_LOAD, 5, 5, 0, 64);
    queue_word(vhfc_pkg::ACT_CULL, 0, 0, 63, 127);
    queue_word(vhfc_pkg::ACT_CULL, 0, 0, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 0, 0, 31, 85);
    queue_word(vhfc_pkg::ACT_CULL, 1, 0, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 63, 63, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 16, 3, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 3, 16, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 2, 2, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 2, 2, 1, 0);
    queue_word(vhfc_pkg::ACT_CULL, 15, 15, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 5, 5, 2, 0);
    queue_word(vhfc_pkg::ACT_CULL, 5, 5, 3, 0);
    queue_word(vhfc_pkg::ACT_CULL, 5, 5, 18, 0);
    queue_word(vhfc_pkg::ACT_CULL, 5, 5, 20, 0);
    queue_word(vhfc_pkg::ACT_CULL, 5, 5, 63, 127);
    queue_word(vhfc_pkg::ACT_CULL, 4, 5, 0, 0);
    queue_word(vhfc_pkg::ACT_CULL, 0, 1, 62, 0);
    wait_drained();

    set_chunk(vhfc_pkg::ORIGIN_W'($urandom), vhfc_pkg::ORIGIN_W'($urandom), 7'd4, 7'd7);
    queue_random(30);
    // Hold the input until every face of the first half is out.
    wait_drained();
    queue_random(30);
    wait_drained();

    send_idle_pct = 78;
    recv_idle_pct = 36;
    set_chunk(vhfc_pkg::ORIGIN_W'($urandom), vhfc_pkg::ORIGIN_W'($urandom), 7'd0, 7'd5);
    queue_random(6);
    wait_drained();
    set_chunk(21'h0FFFFF, 21'h100000, 7'd127, 7'd64);
    // The column loaded beyond the old size comes into the chunk now.
    for (int y = 0; y < 6; y++) begin
      queue_word(vhfc_pkg::ACT_CULL, 63, 63, y, 0);
    end
    queue_word(vhfc_pkg::ACT_CULL, 62, 63, 0, 0);
    queue_random(60);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_chunk(vhfc_pkg::ORIGIN_W'($urandom), vhfc_pkg::ORIGIN_W'($urandom), 7'd1, 7'd1);
    queue_random(10);
    wait_drained();
    set_chunk(vhfc_pkg::ORIGIN_W'($urandom), vhfc_pkg::ORIGIN_W'($urandom),
              7'($urandom_range(MAX_SIDE, 2)), 7'($urandom_range(MAX_SIDE, 2)));
    queue_random(45);
    wait_drained();

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout: %0d face words still pending", faces_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
